[rtl/dlsw_pkg.sv]
// shared types and constants for the display line status and window mask unit
package dlsw_pkg;

    localparam int LINES_PER_FRAME = 228;
    localparam int LINE_WIDTH      = 240;

    localparam int REQ_W    = 3;
    localparam int X_W      = 8;
    localparam int LINE_W   = 8;
    localparam int SKIP_W   = 8;
    localparam int CIDX_W   = 3;
    localparam int CDATA_W  = 32;
    localparam int RES_W    = 18;
    localparam int OUT_W    = 24;

    localparam logic [LINE_W-1:0] LAST_LINE_NUM = LINE_W'(LINES_PER_FRAME);
    localparam logic [X_W-1:0]    LINE_WIDTH_X  = X_W'(LINE_WIDTH);

    typedef enum logic [REQ_W-1:0] {
        REQ_HBLANK    = 3'd0,
        REQ_VBLANK    = 3'd1,
        REQ_LINE_START = 3'd2,
        REQ_NEXT_LINE = 3'd3,
        REQ_PIXEL     = 3'd4
    } req_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_MATCH_TARGET = 3'd0,
        CFG_IRQ_ENABLE   = 3'd1,
        CFG_FRAME_SKIP   = 3'd2,
        CFG_WHITE_FILL   = 3'd3,
        CFG_WIN_ON       = 3'd4,
        CFG_WIN_H        = 3'd5,
        CFG_WIN_V        = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [LINE_W-1:0] match_target;
        logic [2:0]        irq_enable;
        logic [SKIP_W-1:0] frame_skip;
        logic              white_fill;
        logic [1:0]        win_on;
        logic [31:0]       win_h;
        logic [31:0]       win_v;
    } cfg_t;

    // result fields, highest bit first
    typedef struct packed {
        logic              inside_one;
        logic              inside_zero;
        logic              blank_line;
        logic              draw_line;
        logic              irq_line_match;
        logic              irq_vblank;
        logic              irq_hblank;
        logic [LINE_W-1:0] line_number;
        logic              match_status;
        logic              hblank_status;
        logic              vblank_status;
    } res_t;

endpackage

[rtl/dlsw_window.sv]
// inside test for one window with wraparound bounds
module dlsw_window (
    input  logic                        enable,
    input  logic [15:0]                 h_bounds,
    input  logic [15:0]                 v_bounds,
    input  logic [dlsw_pkg::LINE_W-1:0] line,
    input  logic [dlsw_pkg::X_W-1:0]    x,
    output logic                        in_win
);
    import dlsw_pkg::*;

    logic [7:0] left;
    logic [7:0] right;
    logic [7:0] top;
    logic [7:0] bottom;
    logic       v_in;
    logic       h_in;

    assign left   = h_bounds[15:8];
    assign right  = h_bounds[7:0];
    assign top    = v_bounds[15:8];
    assign bottom = v_bounds[7:0];

    always_comb
    begin
        if (top <= bottom)
        begin
            v_in = (line >= top) && (line < bottom);
        end
        else
        begin
            v_in = (line >= top) || (line < bottom);
        end
        // left equal to right covers the whole line
        if (left < right)
        begin
            h_in = (x >= left) && (x < right);
        end
        else
        begin
            h_in = (x >= left) || (x < right);
        end
    end

    assign in_win = enable && (x < LINE_WIDTH_X) && v_in && h_in;

endmodule

[rtl/dlsw_core.sv]
// line status state and per-request result logic
module dlsw_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic [dlsw_pkg::REQ_W-1:0]  req,
    input  logic [dlsw_pkg::X_W-1:0]    px,
    input  dlsw_pkg::cfg_t              cfg,
    output dlsw_pkg::res_t              res
);
    import dlsw_pkg::*;

    logic [LINE_W-1:0] line_reg;
    logic [LINE_W-1:0] line_next;
    logic              vblank_reg;
    logic              vblank_next;
    logic              hblank_reg;
    logic              hblank_next;
    logic              match_reg;
    logic              match_next;
    logic [SKIP_W-1:0] skip_reg;
    logic [SKIP_W-1:0] skip_next;

    logic [LINE_W:0]   line_inc;
    logic [SKIP_W:0]   skip_inc;
    logic              line_hit;
    logic              in0;
    logic              in1;

    dlsw_window u_win0 (
        .enable   (cfg.win_on[0]),
        .h_bounds (cfg.win_h[15:0]),
        .v_bounds (cfg.win_v[15:0]),
        .line     (line_reg),
        .x        (px),
        .in_win   (in0)
    );

    dlsw_window u_win1 (
        .enable   (cfg.win_on[1]),
        .h_bounds (cfg.win_h[31:16]),
        .v_bounds (cfg.win_v[31:16]),
        .line     (line_reg),
        .x        (px),
        .in_win   (in1)
    );

    assign line_inc = {1'b0, line_reg} + (LINE_W+1)'(1);
    assign skip_inc = {1'b0, skip_reg} + (SKIP_W+1)'(1);
    assign line_hit = (line_reg == cfg.match_target);

    always_comb
    begin
        line_next   = line_reg;
        vblank_next = vblank_reg;
        hblank_next = hblank_reg;
        match_next  = match_reg;
        skip_next   = skip_reg;
        res         = '0;
        unique case (req_t'(req))
            REQ_HBLANK:
            begin
                vblank_next    = 1'b0;
                hblank_next    = 1'b1;
                res.irq_hblank = cfg.irq_enable[0];
            end
            REQ_VBLANK:
            begin
                vblank_next = 1'b1;
                hblank_next = 1'b0;
                // wrap by compare so a lowered skip setting recovers at once
                if (cfg.frame_skip != '0)
                begin
                    if (skip_inc >= {1'b0, cfg.frame_skip})
                    begin
                        skip_next = '0;
                    end
                    else
                    begin
                        skip_next = skip_inc[SKIP_W-1:0];
                    end
                end
                res.irq_vblank = cfg.irq_enable[1];
            end
            REQ_LINE_START:
            begin
                vblank_next    = 1'b0;
                hblank_next    = 1'b0;
                res.draw_line  = (cfg.frame_skip == '0) || (skip_reg == '0);
                res.blank_line = res.draw_line && cfg.white_fill;
            end
            REQ_NEXT_LINE:
            begin
                match_next = line_hit;
                if (line_inc >= {1'b0, LAST_LINE_NUM})
                begin
                    line_next = '0;
                end
                else
                begin
                    line_next = line_inc[LINE_W-1:0];
                end
                res.irq_line_match = line_hit && cfg.irq_enable[2];
            end
            REQ_PIXEL:
            begin
                res.inside_zero = in0;
                res.inside_one  = in1;
            end
            default:
            begin
            end
        endcase
        res.vblank_status = vblank_next;
        res.hblank_status = hblank_next;
        res.match_status  = match_next;
        res.line_number   = line_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg   <= '0;
            vblank_reg <= 1'b0;
            hblank_reg <= 1'b0;
            match_reg  <= 1'b0;
            skip_reg   <= '0;
        end
        else if (advance)
        begin
            line_reg   <= line_next;
            vblank_reg <= vblank_next;
            hblank_reg <= hblank_next;
            match_reg  <= match_next;
            skip_reg   <= skip_next;
        end
    end

endmodule

[rtl/display_line_status_and_window_mask.sv]
// top level: request register, status core, result register and config registers
//
// One request enters per clock and one result leaves per clock as long as the
// result side keeps taking. A request sits in the input register while the
// status core updates the line counter, blank and match flags and skip counter
// and evaluates the two window tests, then the result is held in the output
// register. The input side keeps accepting while a finished result waits, as
// long as the input register can move on. Configuration writes are always
// accepted and take effect from the next cycle.
module display_line_status_and_window_mask (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // pixel_x
    input  logic [dlsw_pkg::REQ_W-1:0]    s_tuser,   // req_type
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // vblank_status, hblank_status, line_match_status, line_number[7:0],
    // irq_hblank, irq_vblank, irq_line_match, draw_line, blank_line,
    // inside_window_zero, inside_window_one, zero pad
    output logic [dlsw_pkg::OUT_W-1:0]    m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dlsw_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [dlsw_pkg::CDATA_W-1:0]  cfg_data
);
    import dlsw_pkg::*;

    logic             in_valid_reg;
    logic [REQ_W-1:0] in_req_reg;
    logic [X_W-1:0]   in_px_reg;
    logic             out_valid_reg;
    res_t             out_res_reg;
    cfg_t             cfg_reg;
    res_t             res;
    logic             advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {(OUT_W-RES_W)'(0),
                        out_res_reg.inside_one,
                        out_res_reg.inside_zero,
                        out_res_reg.blank_line,
                        out_res_reg.draw_line,
                        out_res_reg.irq_line_match,
                        out_res_reg.irq_vblank,
                        out_res_reg.irq_hblank,
                        out_res_reg.line_number,
                        out_res_reg.match_status,
                        out_res_reg.hblank_status,
                        out_res_reg.vblank_status};

    dlsw_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .req     (in_req_reg),
        .px      (in_px_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_req_reg <= s_tuser;
            in_px_reg  <= s_tdata;
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MATCH_TARGET: cfg_reg.match_target <= cfg_data[LINE_W-1:0];
                CFG_IRQ_ENABLE:   cfg_reg.irq_enable   <= cfg_data[2:0];
                CFG_FRAME_SKIP:   cfg_reg.frame_skip   <= cfg_data[SKIP_W-1:0];
                CFG_WHITE_FILL:   cfg_reg.white_fill   <= cfg_data[0];
                CFG_WIN_ON:       cfg_reg.win_on       <= cfg_data[1:0];
                CFG_WIN_H:        cfg_reg.win_h        <= cfg_data;
                CFG_WIN_V:        cfg_reg.win_v        <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

endmodule

[rtl/dlsw_checker.sv]
// port-level checks for the display line status and window mask unit
module dlsw_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [dlsw_pkg::OUT_W-1:0]   m_tdata
);
    import dlsw_pkg::*;

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // line counter stays within the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[10:3] < LAST_LINE_NUM))
        else $error("line number out of range");

    // both blank flags never set together
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("hblank and vblank both set");

    // a forced blank line is always a drawn line
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[15] |-> m_tdata[14])
        else $error("blank without draw");

    // one request kind per result: pulses, draw and window marks exclude
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($countones(m_tdata[14:11]) <= 1)
                  && !((m_tdata[16] || m_tdata[17]) && (m_tdata[14:11] != 4'b0000)))
        else $error("result mixes request kinds");

endmodule

bind display_line_status_and_window_mask dlsw_checker u_dlsw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[bench/dlsw_status_checker.sv]
`timescale 1ns / 1ps
// checker for the line status unit: tracks requests, predicts each result and compares it
module dlsw_status_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // pixel_x
    input  logic [dlsw_pkg::REQ_W-1:0]   s_tuser,   // req_type
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    // vblank_status, hblank_status, line_match_status, line_number[7:0],
    // irq_hblank, irq_vblank, irq_line_match, draw_line, blank_line,
    // inside_window_zero, inside_window_one, zero pad
    input  logic [dlsw_pkg::OUT_W-1:0]   m_tdata,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [dlsw_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [dlsw_pkg::CDATA_W-1:0] cfg_data,
    output int                           fail_count,
    output int                           pending
);
    import dlsw_pkg::*;

    cfg_t              regs;
    logic [LINE_W-1:0] line_cnt;
    logic              vblank_f;
    logic              hblank_f;
    logic              match_f;
    logic [SKIP_W-1:0] skip_cnt;

    res_t status_q[$];
    res_t got;
    res_t want;
    int   mismatches;
    int   result_no;

    // window test with wraparound on both axes
    function automatic logic window_hit(input int sel, input logic [X_W-1:0] x);
        logic [15:0] hb;
        logic [15:0] vb;
        logic        vin;
        logic        hin;
        hb = sel ? regs.win_h[31:16] : regs.win_h[15:0];
        vb = sel ? regs.win_v[31:16] : regs.win_v[15:0];
        if (!regs.win_on[sel] || x >= LINE_WIDTH_X)
            return 1'b0;
        if (vb[15:8] <= vb[7:0])
            vin = (line_cnt >= vb[15:8]) && (line_cnt < vb[7:0]);
        else
            vin = (line_cnt >= vb[15:8]) || (line_cnt < vb[7:0]);
        if (hb[15:8] < hb[7:0])
            hin = (x >= hb[15:8]) && (x < hb[7:0]);
        else
            hin = (x >= hb[15:8]) || (x < hb[7:0]);
        return vin && hin;
    endfunction

    // applies one event to the tracked display state and returns its status
    function automatic res_t advance_display(input logic [REQ_W-1:0] req,
                                             input logic [X_W-1:0] x);
        res_t       o;
        logic [8:0] nxt;
        logic       hit;
        o = '0;
        case (req)
            REQ_HBLANK:
            begin
                vblank_f = 1'b0;
                hblank_f = 1'b1;
                o.irq_hblank = regs.irq_enable[0];
            end
            REQ_VBLANK:
            begin
                vblank_f = 1'b1;
                hblank_f = 1'b0;
                if (regs.frame_skip != '0)
                begin
                    // compare, not modulo: a stale counter above the limit returns to zero
                    nxt = {1'b0, skip_cnt} + 9'd1;
                    skip_cnt = (nxt >= {1'b0, regs.frame_skip}) ? '0 : nxt[7:0];
                end
                o.irq_vblank = regs.irq_enable[1];
            end
            REQ_LINE_START:
            begin
                vblank_f = 1'b0;
                hblank_f = 1'b0;
                o.draw_line  = (regs.frame_skip == '0) || (skip_cnt == '0);
                o.blank_line = o.draw_line & regs.white_fill;
            end
            REQ_NEXT_LINE:
            begin
                hit = (line_cnt == regs.match_target);
                nxt = {1'b0, line_cnt} + 9'd1;
                line_cnt = (nxt >= 9'(LINES_PER_FRAME)) ? '0 : nxt[7:0];
                match_f = hit;
                o.irq_line_match = hit & regs.irq_enable[2];
            end
            REQ_PIXEL:
            begin
                o.inside_zero = window_hit(0, x);
                o.inside_one  = window_hit(1, x);
            end
            default: ;
        endcase
        o.vblank_status = vblank_f;
        o.hblank_status = hblank_f;
        o.match_status  = match_f;
        o.line_number   = line_cnt;
        return o;
    endfunction

    function automatic string fmt_status(input res_t r);
        return $sformatf("vb %b hb %b lm %b line %0d irq h%b v%b m%b draw %b blank %b win %b%b",
                         r.vblank_status, r.hblank_status, r.match_status, r.line_number,
                         r.irq_hblank, r.irq_vblank, r.irq_line_match, r.draw_line,
                         r.blank_line, r.inside_zero, r.inside_one);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs       = '0;
            line_cnt   = '0;
            vblank_f   = 1'b0;
            hblank_f   = 1'b0;
            match_f    = 1'b0;
            skip_cnt   = '0;
            status_q.delete();
            mismatches = 0;
            result_no  = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                status_q.push_back(advance_display(s_tuser, s_tdata));

            if (m_tvalid && m_tready)
            begin
                got = res_t'(m_tdata[RES_W-1:0]);
                if (status_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with no request pending: %h",
                                 result_no, m_tdata);
                end
                else
                begin
                    want = status_q.pop_front();
                    if (got.vblank_status  !== want.vblank_status  ||
                        got.hblank_status  !== want.hblank_status  ||
                        got.match_status   !== want.match_status   ||
                        got.line_number    !== want.line_number    ||
                        got.irq_hblank     !== want.irq_hblank     ||
                        got.irq_vblank     !== want.irq_vblank     ||
                        got.irq_line_match !== want.irq_line_match ||
                        got.draw_line      !== want.draw_line      ||
                        got.blank_line     !== want.blank_line     ||
                        got.inside_zero    !== want.inside_zero    ||
                        got.inside_one     !== want.inside_one     ||
                        m_tdata[OUT_W-1:RES_W] !== '0)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d mismatch: expected %s, got %s (raw %h)",
                                     result_no, fmt_status(want), fmt_status(got), m_tdata);
                    end
                end
                result_no++;
            end

            // register writes land after any request of the same edge
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MATCH_TARGET: regs.match_target = cfg_data[LINE_W-1:0];
                    CFG_IRQ_ENABLE:   regs.irq_enable   = cfg_data[2:0];
                    CFG_FRAME_SKIP:   regs.frame_skip   = cfg_data[SKIP_W-1:0];
                    CFG_WHITE_FILL:   regs.white_fill   = cfg_data[0];
                    CFG_WIN_ON:       regs.win_on       = cfg_data[1:0];
                    CFG_WIN_H:        regs.win_h        = cfg_data;
                    CFG_WIN_V:        regs.win_v        = cfg_data;
                    default: ;
                endcase
            end

            fail_count <= mismatches;
            pending    <= status_q.size();
        end
    end

endmodule

[bench/tb_display_line_status_and_window_mask.sv]
`timescale 1ns / 1ps
// testbench top: drives events and register writes into the line status unit, gives the verdict
module tb_display_line_status_and_window_mask;
    import dlsw_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 105;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;   // pixel_x
    logic [REQ_W-1:0]    s_tuser;   // req_type
    logic                m_tvalid;
    logic                m_tready;
    // vblank_status, hblank_status, line_match_status, line_number[7:0],
    // irq_hblank, irq_vblank, irq_line_match, draw_line, blank_line,
    // inside_window_zero, inside_window_one, zero pad
    logic [OUT_W-1:0]    m_tdata;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CIDX_W-1:0]   cfg_index;
    logic [CDATA_W-1:0]  cfg_data;

    int fail_count;
    int pending;
    int cycles      = 0;
    int rx_hold     = 0;   // long receiver hold-off, in cycles
    int rx_low_left = 0;
    bit tx_steady   = 1'b0;
    bit rx_steady   = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    display_line_status_and_window_mask u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dlsw_status_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side: random stalls, steady stretches and one long hold-off
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                m_tready <= 1'b0;
            else if (rx_hold > 0)
            begin
                m_tready <= 1'b0;
                rx_hold--;
            end
            else if (rx_low_left > 0)
            begin
                m_tready <= 1'b0;
                rx_low_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!rx_steady)
                    rx_low_left = pick_gap();
            end
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [CDATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_req(input logic [REQ_W-1:0] req, input logic [7:0] x);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= x;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [REQ_W-1:0] req;
        logic [7:0]       x;
        int               r;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // window zero 10..19 on lines 0..4, window one wraps on both axes
        write_reg(CFG_MATCH_TARGET, 32'h0000_0000);
        write_reg(CFG_IRQ_ENABLE,   32'hFFFF_FFFF);
        write_reg(CFG_FRAME_SKIP,   32'h0000_0000);
        write_reg(CFG_WHITE_FILL,   32'h0000_0001);
        write_reg(CFG_WIN_ON,       32'h0000_0003);
        write_reg(CFG_WIN_H,        32'hC808_0A14);
        write_reg(CFG_WIN_V,        32'hC803_0005);
        send_req(REQ_HBLANK,     8'h00);
        send_req(REQ_VBLANK,     8'hFF);
        send_req(REQ_LINE_START, 8'h00);
        send_req(REQ_PIXEL,      8'd10);
        send_req(REQ_PIXEL,      8'd19);
        send_req(REQ_PIXEL,      8'd20);
        send_req(REQ_PIXEL,      8'd7);
        send_req(REQ_PIXEL,      8'd239);
        send_req(REQ_PIXEL,      8'd240);   // beyond the line
        send_req(REQ_PIXEL,      8'd255);
        send_req(REQ_NEXT_LINE,  8'h00);    // line zero matches the target
        send_req(3'd5,           8'hAA);    // unknown requests
        send_req(3'd7,           8'h55);
        drain();

        // left equal to right spans the whole line; window zero off
        write_reg(CFG_WIN_H,  32'h3232_0A14);
        write_reg(CFG_WIN_ON, 32'h0000_0002);
        send_req(REQ_PIXEL, 8'd0);
        send_req(REQ_PIXEL, 8'd239);
        drain();

        // frame skip, then the limit lowered below the running counter
        write_reg(CFG_FRAME_SKIP, 32'h0000_0003);
        send_req(REQ_VBLANK,     8'h00);
        send_req(REQ_VBLANK,     8'h00);
        send_req(REQ_LINE_START, 8'h00);
        drain();
        write_reg(CFG_FRAME_SKIP, 32'h0000_0001);
        send_req(REQ_VBLANK,     8'h00);
        send_req(REQ_LINE_START, 8'h00);
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph == 0)
            begin
                write_reg(CFG_MATCH_TARGET, 32'hFFFF_FFFF);
                write_reg(CFG_IRQ_ENABLE,   32'hFFFF_FFFF);
                write_reg(CFG_FRAME_SKIP,   32'hFFFF_FFFF);
                write_reg(CFG_WHITE_FILL,   32'hFFFF_FFFF);
                write_reg(CFG_WIN_ON,       32'hFFFF_FFFF);
                write_reg(CFG_WIN_H,        32'hFFFF_FFFF);
                write_reg(CFG_WIN_V,        32'hFFFF_FFFF);
            end
            else if (ph == 1)
            begin
                write_reg(CFG_MATCH_TARGET, 32'h0);
                write_reg(CFG_IRQ_ENABLE,   32'h0);
                write_reg(CFG_FRAME_SKIP,   32'h0);
                write_reg(CFG_WHITE_FILL,   32'h0);
                write_reg(CFG_WIN_ON,       32'h0);
                write_reg(CFG_WIN_H,        32'h0);
                write_reg(CFG_WIN_V,        32'h0);
            end
            else
            begin
                r = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 255);
                write_reg(CFG_MATCH_TARGET, {24'($urandom_range(0, 32'h00FF_FFFF)), 8'(r)});
                write_reg(CFG_IRQ_ENABLE,   $urandom());
                r = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 4) : $urandom_range(0, 255);
                write_reg(CFG_FRAME_SKIP,   {24'($urandom_range(0, 32'h00FF_FFFF)), 8'(r)});
                write_reg(CFG_WHITE_FILL,   $urandom());
                write_reg(CFG_WIN_ON,       $urandom());
                write_reg(CFG_WIN_H,        $urandom());
                write_reg(CFG_WIN_V,        $urandom());
            end

            tx_steady = (ph == 3) || (ph == 5);
            rx_steady = (ph == 3);
            if (ph == 5)
                rx_hold = 400;   // sender keeps offering until the block backs up

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 38)
                    req = REQ_NEXT_LINE;
                else if (r < 73)
                    req = REQ_PIXEL;
                else if (r < 81)
                    req = REQ_HBLANK;
                else if (r < 88)
                    req = REQ_VBLANK;
                else if (r < 96)
                    req = REQ_LINE_START;
                else
                    req = REQ_W'($urandom_range(5, 7));
                x = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(240, 255))
                                                : 8'($urandom_range(0, 239));
                send_req(req, x);
            end
            drain();
        end

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
